// ===== rtl/core/rc4ks_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4ks_pkg: shared types and constants for the RC4 keystream generator.
// Holds the default table size, field widths, operation codes and the
// controller state type.
// ----------------------------------------------------------------------------
package rc4ks_pkg;

	// Default number of permutation entries.
	localparam int TABLE_SIZE_DEF = 256;

	// Widths of the key and keystream fields.
	localparam int KEY_W = 8;
	localparam int KS_W  = 8;

	// Operation codes carried in the operation field.
	localparam logic OP_KEY = 1'b0;
	localparam logic OP_GEN = 1'b1;

	// Controller state: table clearing pass after reset, then normal running.
	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} ctrl_state_t;

endpackage

// ===== rtl/core/rc4_keystream_generator.sv =====
// ----------------------------------------------------------------------------
// rc4_keystream_generator: RC4 key scheduling and keystream generation.
// A generate word passes from the input register through the engine steps and
// the output queue to the keystream port.
// Flow: the engine starts a new word only once the previous word has read S[j]
// and S[t], so the reads of S[i], S[j] and S[t] share the one read port.
// Reset: indices clear at once; a clearing pass then loads the identity table,
// while one word may wait in the input register.
// ----------------------------------------------------------------------------
module rc4_keystream_generator import rc4ks_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic             operation,
	input  logic [KEY_W-1:0] key_value,
	output logic             keystream_valid,
	input  logic             keystream_ready,
	output logic [KS_W-1:0]  keystream_value
);

	localparam int OUT_DEPTH = 2;
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

	// Input register.
	logic             in_v_q;
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic             take, in_acc;

	// Output queue and result credits.
	logic [KS_W-1:0]  ks_q [OUT_DEPTH];
	logic             wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q, credit_q;
	logic             res_valid, out_acc, gen_start, gen_ok;
	logic [KS_W-1:0]  res_data;

	assign item_ready = !in_v_q || take;
	assign in_acc     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_q <= 1'b0;
		end else if (item_ready) begin
			in_v_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= operation;
			key_q <= key_value;
		end
	end

	rc4ks_core #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (in_v_q),
		.item_op    (op_q),
		.item_key   (key_q),
		.gen_ok     (gen_ok),
		.item_take  (take),
		.res_valid  (res_valid),
		.res_data   (res_data)
	);

	// A generate word enters the engine only with a queue slot reserved for it.
	assign out_acc   = keystream_valid && keystream_ready;
	assign gen_start = take && (op_q == OP_GEN);
	assign gen_ok    = (credit_q < CNT_W'(OUT_DEPTH)) || out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CNT_W'(gen_start) - CNT_W'(out_acc);
		end
	end

	// Two-entry output queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_acc) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + CNT_W'(res_valid) - CNT_W'(out_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			ks_q[wr_ptr_q] <= res_data;
		end
	end

	assign keystream_valid = (fill_q != '0);
	assign keystream_value = ks_q[rd_ptr_q];

endmodule

// ===== rtl/core/rc4ks_perm_ram.sv =====
// ----------------------------------------------------------------------------
// rc4ks_perm_ram: permutation table storage.
// Simple dual-port memory with one write port and one read port; the read
// data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module rc4ks_perm_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; a read of the entry being written returns old data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/rc4ks_core.sv =====
// ----------------------------------------------------------------------------
// rc4ks_core: RC4 swap engine around the permutation table.
// Runs a clearing pass that loads the identity after reset, then handles one
// word at a time through four steps: read S[i], read S[j], write S[i] and
// read S[t], write S[j] and deliver the keystream entry. The last step
// overlaps the first step of the next word.
// ----------------------------------------------------------------------------
module rc4ks_core import rc4ks_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	// Pending word from the input register.
	input  logic            item_valid,
	input  logic            item_op,
	input  logic [KEY_W-1:0] item_key,
	input  logic            gen_ok,
	output logic            item_take,
	// Keystream result toward the output queue.
	output logic            res_valid,
	output logic [KS_W-1:0] res_data
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [IDX_W:0]   SIZE_EXT = (IDX_W + 1)'(TABLE_SIZE);
	localparam logic [KEY_W+3:0] SIZE_KEY = (KEY_W + 4)'(TABLE_SIZE);

	// Sum of two table values, reduced once against the table size.
	function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= SIZE_EXT) begin
			s = s - SIZE_EXT;
		end
		return s[IDX_W-1:0];
	endfunction

	// Index increment with wrap at the table size.
	function automatic logic [IDX_W-1:0] inc_mod(input logic [IDX_W-1:0] a);
		logic [IDX_W-1:0] r;
		r = (a == LAST_IDX) ? '0 : a + IDX_W'(1);
		return r;
	endfunction

	// Key reduction by restoring subtraction; the quotient fits in four bits.
	function automatic logic [IDX_W-1:0] key_mod(input logic [KEY_W-1:0] k);
		logic [KEY_W+3:0] v;
		v = (KEY_W + 4)'(k);
		for (int s = 3; s >= 0; s--) begin
			if (v >= (SIZE_KEY << s)) begin
				v = v - (SIZE_KEY << s);
			end
		end
		return v[IDX_W-1:0];
	endfunction

	// Controller state and clearing counter.
	ctrl_state_t state_q, state_d;
	logic [IDX_W-1:0] clr_cnt_q;
	logic clr_busy, run;

	// Index registers.
	logic [IDX_W-1:0] sched_idx_q, sched_mix_q, gen_idx_q, gen_mix_q;

	// Step valids.
	logic v_s1, v_s2, v_s3;

	// Step payloads.
	logic             op_s1, op_s2, op_s3;
	logic [IDX_W-1:0] i_s1, i_s2, i_s3;
	logic [IDX_W-1:0] jbase_s1, keym_s1;
	logic             fwd_s1;
	logic [IDX_W-1:0] fwd_data_s1;
	logic [IDX_W-1:0] j_s2, j_s3;
	logic [IDX_W-1:0] si_s2, si_s3, sj_s3, t_s3;

	// Memory port signals.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

	// First-step signals.
	logic             is_key_a, new_sched_a, start_a, fwd_a;
	logic [IDX_W-1:0] i_a, jbase_a;

	// Later-step signals.
	logic [IDX_W-1:0] si_b, mix_b, j_b, sj_c, t_c, ks_d;

	rc4ks_perm_ram #(
		.DEPTH  (TABLE_SIZE),
		.ADDR_W (IDX_W),
		.DATA_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Controller next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_IDX) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN:   state_d = ST_RUN;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// Controller outputs.
	always_comb begin
		clr_busy = 1'b0;
		run      = 1'b0;
		case (state_q)
			ST_CLEAR: clr_busy = 1'b1;
			ST_RUN:   run      = 1'b1;
			default:  clr_busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_busy) begin
				clr_cnt_q <= inc_mod(clr_cnt_q);
			end
		end
	end

	// First step: pick i, the base of j, and catch a write of the same entry.
	always_comb begin
		is_key_a    = (item_op == OP_KEY);
		new_sched_a = (sched_idx_q == '0);
		start_a     = run && item_valid && !v_s1 && !v_s2 && (is_key_a || gen_ok);
		i_a         = is_key_a ? sched_idx_q : inc_mod(gen_idx_q);
		jbase_a     = is_key_a ? (new_sched_a ? '0 : sched_mix_q) : gen_mix_q;
		fwd_a       = v_s3 && (j_s3 == i_a);
	end

	assign item_take = start_a;

	// Second step: S[i] is in hand, form the new j.
	always_comb begin
		si_b  = fwd_s1 ? fwd_data_s1 : ram_rdata;
		mix_b = add_mod(jbase_s1, si_b);
		j_b   = (op_s1 == OP_KEY) ? add_mod(mix_b, keym_s1) : mix_b;
	end

	// Third step: S[j] is in hand, form the output index.
	always_comb begin
		sj_c = ram_rdata;
		t_c  = add_mod(si_s2, sj_c);
	end

	// Fourth step: output entry as seen after the swap.
	always_comb begin
		if (t_s3 == i_s3) begin
			ks_d = sj_s3;
		end else if (t_s3 == j_s3) begin
			ks_d = si_s3;
		end else begin
			ks_d = ram_rdata;
		end
	end

	assign res_valid = v_s3 && (op_s3 == OP_GEN);
	assign res_data  = KS_W'(ks_d);

	// Memory address and write selection; at most one step uses each port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_s2;
		ram_wdata = sj_c;
		if (clr_busy) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = clr_cnt_q;
		end else if (v_s2) begin
			ram_we    = 1'b1;
			ram_waddr = i_s2;
			ram_wdata = sj_c;
		end else if (v_s3) begin
			ram_we    = 1'b1;
			ram_waddr = j_s3;
			ram_wdata = si_s3;
		end

		if (v_s1) begin
			ram_raddr = j_b;
		end else if (v_s2) begin
			ram_raddr = t_c;
		end else begin
			ram_raddr = i_a;
		end
	end

	// Index registers: the key step at index zero restarts both schedules.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_idx_q <= '0;
			sched_mix_q <= '0;
			gen_idx_q   <= '0;
			gen_mix_q   <= '0;
		end else begin
			if (start_a) begin
				if (is_key_a) begin
					sched_idx_q <= inc_mod(sched_idx_q);
					if (new_sched_a) begin
						gen_idx_q <= '0;
						gen_mix_q <= '0;
					end
				end else begin
					gen_idx_q <= i_a;
				end
			end
			if (v_s1) begin
				if (op_s1 == OP_KEY) begin
					sched_mix_q <= j_b;
				end else begin
					gen_mix_q <= j_b;
				end
			end
		end
	end

	// Step valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start_a;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Step payloads.
	always_ff @(posedge clk) begin
		op_s1       <= item_op;
		i_s1        <= i_a;
		jbase_s1    <= jbase_a;
		keym_s1     <= key_mod(item_key);
		fwd_s1      <= fwd_a;
		fwd_data_s1 <= si_s3;

		op_s2 <= op_s1;
		i_s2  <= i_s1;
		j_s2  <= j_b;
		si_s2 <= si_b;

		op_s3 <= op_s2;
		i_s3  <= i_s2;
		j_s3  <= j_s2;
		si_s3 <= si_s2;
		sj_s3 <= sj_c;
		t_s3  <= t_c;
	end

endmodule

// ===== rtl/core/rc4ks_checker.sv =====
// ----------------------------------------------------------------------------
// rc4ks_checker: port-level checks for the RC4 keystream generator.
// Tracks generate words taken in against keystream words delivered.
// ----------------------------------------------------------------------------
module rc4ks_checker import rc4ks_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             operation,
	input logic             keystream_valid,
	input logic             keystream_ready,
	input logic [KS_W-1:0]  keystream_value
);

	// Generate words accepted whose keystream word is not yet delivered.
	logic [2:0] pend_q;
	logic       gen_in, ks_out;

	assign gen_in = item_valid && item_ready && (operation == OP_GEN);
	assign ks_out = keystream_valid && keystream_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(gen_in) - 3'(ks_out);
		end
	end

	// A stalled keystream word stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		keystream_valid && !keystream_ready |=> keystream_valid && $stable(keystream_value))
		else $error("keystream word changed while stalled");

	// A keystream word is shown only for an accepted generate word.
	assert property (@(posedge clk) disable iff (!arst_n)
		keystream_valid |-> pend_q != 3'd0)
		else $error("keystream word without a generate word");

	// At most the input register, the engine slot and the queue hold words.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("too many generate words outstanding");

	// Key words alone never raise the keystream valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(keystream_valid) |-> $past(pend_q) != 3'd0 || $past(gen_in))
		else $error("keystream valid rose with no generate word pending");

endmodule

bind rc4_keystream_generator rc4ks_checker u_rc4ks_checker (.*);
